### rtl/tlvp_pkg.sv
// Package: shared types, codes and the tag type table of the TLV parameter parser.
package tlvp_pkg;

  localparam int unsigned NUM_TAGS = 25;
  localparam int unsigned TYPE_TABLE_SIZE = 25;

  typedef enum logic [1:0] {
    TYPE_U8  = 2'd0,
    TYPE_U16 = 2'd1,
    TYPE_U32 = 2'd2,
    TYPE_STR = 2'd3
  } item_type_t;

  typedef enum logic [2:0] {
    KIND_U8   = 3'd0,
    KIND_U16  = 3'd1,
    KIND_U32  = 3'd2,
    KIND_STR  = 3'd3,
    KIND_NONE = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADLEN  = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_TRUNC   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_TAG = 2'd0,
    PH_LEN = 2'd1,
    PH_VAL = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0]  tag;
    kind_t       kind;
    logic [31:0] value;
    status_t     status;
    logic        last_of_item;
  } result_t;

  // Type of a known tag; tags beyond the table read as u8.
  function automatic item_type_t type_of(input logic [7:0] tag);
    item_type_t t;
    case (tag)
      8'd1, 8'd2, 8'd17, 8'd18:        t = TYPE_U16;
      8'd4, 8'd5, 8'd7, 8'd8, 8'd25:   t = TYPE_STR;
      8'd16:                           t = TYPE_U32;
      default:                         t = TYPE_U8;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] expected_len(input item_type_t t);
    logic [7:0] len;
    case (t)
      TYPE_U8:  len = 8'd1;
      TYPE_U16: len = 8'd2;
      default:  len = 8'd4;
    endcase
    return len;
  endfunction

endpackage

### rtl/tlvp_if.sv
// Interfaces: byte stream and result stream channels with valid/ready handshake.
interface tlvp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface tlvp_result_if;
  import tlvp_pkg::*;
  logic        valid;
  logic        ready;
  logic [7:0]  tag;
  kind_t       kind;
  logic [31:0] value;
  status_t     status;
  logic        last_of_item;

  modport source (output valid, output tag, output kind, output value, output status,
                  output last_of_item, input ready);
  modport sink   (input valid, input tag, input kind, input value, input status,
                  input last_of_item, output ready);
endinterface

### rtl/tlvp_out_stage.sv
// Result register: holds one result beat and decouples the output handshake.
module tlvp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tlvp_pkg::result_t res,
  output logic              can_take,
  tlvp_result_if.source     results
);
  import tlvp_pkg::*;

  logic    valid;
  result_t data;

  // Free when empty or when the held beat leaves this cycle.
  assign can_take = !valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_take) begin
      valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && push) begin
      data <= res;
    end
  end

  assign results.valid        = valid;
  assign results.tag          = data.tag;
  assign results.kind         = data.kind;
  assign results.value        = data.value;
  assign results.status       = data.status;
  assign results.last_of_item = data.last_of_item;

endmodule

### rtl/tag_length_value_param_parser.sv
// Top level: tag-length-value parameter parser, one input byte per cycle.
//
// Takes a byte stream of items (tag byte, length byte, value bytes) and gives
// at most one result beat per input byte. Tags 1..NUM_TAGS are known and typed
// u8, u16, u32 or string from a fixed table (tags past the table are u8).
// Numeric values are assembled big-endian and come out as one beat on their
// last byte; string bytes come out one per beat, last_of_item on the final
// one. Unknown tags and numerics of the wrong length are reported once at the
// length byte, then their value bytes are swallowed. An empty string reports
// at the length byte. end_of_buffer on any byte ends the item: a cut-off item
// reports truncated (a string gives its byte with status truncated), a skipped
// item reports nothing more, and parsing restarts at a tag. Rate: one byte per
// clock while not stalled; a result appears on the output in the cycle after
// its byte is taken. The only thing that throttles input is the single result
// register: bytes are refused only while that register is full and the sink
// does not take its beat.
module tag_length_value_param_parser (
  input  logic         clk,
  input  logic         rst,
  tlvp_byte_if.sink    bytes,
  tlvp_result_if.source results
);
  import tlvp_pkg::*;

  // Parser state
  phase_t      phase,      phase_next;
  logic [7:0]  cur_tag,    cur_tag_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [31:0] acc,        acc_next;
  item_type_t  item_type,  item_type_next;
  logic        skipping,   skipping_next;

  // Step decode
  logic        accept;
  logic        stage_free;
  logic        emit;
  result_t     res;
  logic [7:0]  b;
  logic        eob;
  logic        unknown;
  item_type_t  lut_type;
  logic        len_ok;
  logic [7:0]  left_dec;
  logic        done;

  assign b        = bytes.data_byte;
  assign eob      = bytes.end_of_buffer;
  assign accept   = bytes.valid && bytes.ready;
  assign bytes.ready = stage_free;

  assign unknown  = (cur_tag == 8'd0) || (cur_tag > 8'(NUM_TAGS));
  assign lut_type = type_of(cur_tag);
  assign len_ok   = (lut_type == TYPE_STR) || (b == expected_len(lut_type));
  assign left_dec = bytes_left - 8'd1;
  assign done     = (left_dec == 8'd0);

  // Next state
  always_comb begin
    phase_next      = phase;
    cur_tag_next    = cur_tag;
    bytes_left_next = bytes_left;
    acc_next        = acc;
    item_type_next  = item_type;
    skipping_next   = skipping;
    case (phase)
      PH_LEN: begin
        if (!unknown) begin
          item_type_next = lut_type;
          acc_next       = 32'd0;
        end
        if (b == 8'd0 || eob) begin
          phase_next      = PH_TAG;
          bytes_left_next = 8'd0;
          skipping_next   = 1'b0;
        end else begin
          phase_next      = PH_VAL;
          bytes_left_next = b;
          skipping_next   = unknown || !len_ok;
        end
      end
      PH_VAL: begin
        bytes_left_next = left_dec;
        if (!skipping && item_type != TYPE_STR) begin
          acc_next = {acc[23:0], b};
        end
        if (done || eob) begin
          phase_next      = PH_TAG;
          bytes_left_next = 8'd0;
          skipping_next   = 1'b0;
        end
      end
      default: begin
        // expecting a tag; the unused phase code behaves the same
        cur_tag_next    = b;
        acc_next        = 32'd0;
        phase_next      = eob ? PH_TAG : PH_LEN;
        bytes_left_next = 8'd0;
        skipping_next   = 1'b0;
      end
    endcase
  end

  // Result of this byte
  always_comb begin
    emit             = 1'b0;
    res.tag          = cur_tag_next;
    res.kind         = KIND_NONE;
    res.value        = 32'd0;
    res.status       = ST_OK;
    res.last_of_item = 1'b1;
    case (phase)
      PH_LEN: begin
        emit = 1'b1;
        if (unknown) begin
          res.status = ST_UNKNOWN;
        end else if (!len_ok) begin
          res.status = ST_BADLEN;
        end else if (b == 8'd0) begin
          res.status = ST_OK;
        end else if (eob) begin
          res.status = ST_TRUNC;
        end else begin
          emit = 1'b0;
        end
      end
      PH_VAL: begin
        if (!skipping) begin
          if (item_type == TYPE_STR) begin
            emit             = 1'b1;
            res.kind         = KIND_STR;
            res.value        = {24'd0, b};
            res.status       = (!done && eob) ? ST_TRUNC : ST_OK;
            res.last_of_item = done || eob;
          end else if (done) begin
            emit      = 1'b1;
            res.kind  = kind_t'({1'b0, item_type});
            res.value = {acc[23:0], b};
          end else if (eob) begin
            emit       = 1'b1;
            res.status = ST_TRUNC;
          end
        end
      end
      default: begin
        if (eob) begin
          emit       = 1'b1;
          res.status = ST_TRUNC;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TAG;
      bytes_left <= 8'd0;
      item_type  <= TYPE_U8;
      skipping   <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
      item_type  <= item_type_next;
      skipping   <= skipping_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_tag <= cur_tag_next;
      acc     <= acc_next;
    end
  end

  tlvp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (accept && emit),
    .res      (res),
    .can_take (stage_free),
    .results  (results)
  );

  // Checks
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.kind == KIND_NONE |-> results.value == 32'd0)
    else $error("no-value result carries a value");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.status != ST_OK |-> results.last_of_item)
    else $error("error result not marked last");

  a_eob_tag: assert property (@(posedge clk) disable iff (rst)
    accept && eob |=> phase == PH_TAG)
    else $error("end of buffer did not restart parsing");

  a_skip_val: assert property (@(posedge clk) disable iff (rst)
    skipping |-> phase == PH_VAL && bytes_left != 8'd0)
    else $error("skipping outside a value");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !bytes.ready |-> results.valid && !results.ready)
    else $error("input stalled without a held result");

endmodule
